/* rtl/awu_pkg.sv */
// Shared widths, constants and register codes of the Adagrad weight update block.
`default_nettype none
package awu_pkg;

  // Field widths.
  localparam int INDEX_W = 17;
  localparam int DATA_W  = 32;
  localparam int BATCH_W = 16;
  localparam int ACC_W   = 64;
  localparam int ROOT_W  = 32;

  // Register reset values.
  localparam logic [DATA_W-1:0]  LR_RESET = 32'd655;
  localparam logic [BATCH_W-1:0] BS_RESET = 16'd1;

  // Epsilon 1e-5 in unsigned Q32.32, rounded to nearest.
  localparam logic [ACC_W-1:0] EPS_Q32 = 64'd42950;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_STEP_SIZE    = 1'b0,
    CFG_SAMPLE_COUNT = 1'b1
  } cfg_index_t;

endpackage
`default_nettype wire

/* rtl/awu_in_if.sv */
// Input channel: weight index, weight and gradient sum with valid/ready.
`default_nettype none
interface awu_in_if import awu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [INDEX_W-1:0]       weight_index;
  logic signed [DATA_W-1:0] weight_in;
  logic signed [DATA_W-1:0] gradient_sum;

  modport source (output valid, output weight_index, output weight_in,
                  output gradient_sum, input ready);
  modport sink   (input valid, input weight_index, input weight_in,
                  input gradient_sum, output ready);
endinterface
`default_nettype wire

/* rtl/awu_out_if.sv */
// Result channel: updated weight and saturation flag with valid/ready.
`default_nettype none
interface awu_out_if import awu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] weight_out;
  logic                     saturated;

  modport source (output valid, output weight_out, output saturated, input ready);
  modport sink   (input valid, input weight_out, input saturated, output ready);
endinterface
`default_nettype wire

/* rtl/awu_cfg_if.sv */
// Configuration write channel: register index and data with valid/ready.
`default_nettype none
interface awu_cfg_if import awu_pkg::*; ();
  logic              valid;
  logic              ready;
  cfg_index_t        index;
  logic [DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/adagrad_weight_update.sv */
// Top level of the Adagrad weight update pipeline.
//
// Usage: each transfer on in_ch carries a weight index, a Q16.16 weight and its
// batch gradient sum; each transfer on out_ch returns the updated Q16.16 weight
// and a flag that is set when the accumulator or the weight saturated. cfg_ch
// writes the base step size and the sample count per gradient; it is always
// ready. The user must write it only while no items are in flight; the block
// itself does not enforce this. Throughput is one item per cycle while no
// clearing pass runs and the receiver does not stall. A result passes 121
// register stages, the first loaded at the transfer edge, among them the
// gradient divider (32 stages), square root (32 stages), rate divider (48 stages).
// Accumulators live in a WEIGHT_COUNT-deep RAM, read and written in adjacent
// stages with a one-entry bypass, so back-to-back updates of one index chain.
// After reset, in_ch.ready stays low while a clearing pass zeroes all
// WEIGHT_COUNT entries of the RAM; configuration writes are taken during it.
// When the receiver stalls, the result holds on out_ch and one more result
// lands in a skid register; the pipeline then freezes with nothing lost.
`default_nettype none
module adagrad_weight_update import awu_pkg::*; #(
  parameter int WEIGHT_COUNT = 131072
) (
  input  wire logic clk,
  input  wire logic rst_n,
  awu_in_if.sink    in_ch,
  awu_out_if.source out_ch,
  awu_cfg_if.sink   cfg_ch
);

  localparam int AW = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(WEIGHT_COUNT - 1);
  localparam int S1_W = 1 + INDEX_W + DATA_W;
  localparam int S2_W = DATA_W + DATA_W + 2;
  localparam int DIV2_NW = DATA_W + 16;

  // Configuration registers.
  logic [DATA_W-1:0]  lr_r;
  logic [BATCH_W-1:0] bs_r;
  logic [BATCH_W-1:0] bs_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= LR_RESET;
      bs_r <= BS_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_STEP_SIZE:    lr_r <= cfg_ch.data;
        CFG_SAMPLE_COUNT: bs_r <= cfg_ch.data[BATCH_W-1:0];
        default:          ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign bs_eff = (bs_r == '0) ? BATCH_W'(1) : bs_r;

  // Pipeline advance and clearing pass control.
  logic          adv;
  logic          skid_v_r;
  logic          clearing_r;
  logic [AW-1:0] clr_cnt_r;
  logic          in_xfer;

  assign adv         = !skid_v_r;
  assign in_ch.ready = adv && !clearing_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == CLR_LAST) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Entry stage: gradient magnitude and sign.
  logic               a_v_r;
  logic [INDEX_W-1:0] a_idx_r;
  logic [DATA_W-1:0]  a_w_r;
  logic [DATA_W-1:0]  a_gmag_r;
  logic               a_gneg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_idx_r  <= in_ch.weight_index;
      a_w_r    <= in_ch.weight_in;
      a_gneg_r <= in_ch.gradient_sum[DATA_W-1];
      a_gmag_r <= in_ch.gradient_sum[DATA_W-1] ? (~in_ch.gradient_sum + DATA_W'(1))
                                               : in_ch.gradient_sum;
    end
  end

  // Gradient divided by the batch size.
  logic               d1_v;
  logic [DATA_W-1:0]  d1_q;
  logic [S1_W-1:0]    d1_side;

  awu_div_pipe #(.NW(DATA_W), .DW(BATCH_W), .SW(S1_W)) u_div_grad (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (a_v_r),
    .num      (a_gmag_r),
    .den      (bs_eff),
    .side_in  ({a_gneg_r, a_idx_r, a_w_r}),
    .out_valid(d1_v),
    .quo      (d1_q),
    .side_out (d1_side)
  );

  // Square of the scaled gradient; the RAM read is issued from here.
  logic               b_v_r;
  logic [INDEX_W-1:0] b_idx_r;
  logic [DATA_W-1:0]  b_w_r;
  logic [DATA_W-1:0]  b_g_r;
  logic               b_gneg_r;
  logic [ACC_W-1:0]   b_sq_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      {b_gneg_r, b_idx_r, b_w_r} <= d1_side;
      b_g_r  <= d1_q;
      b_sq_r <= ACC_W'(d1_q) * ACC_W'(d1_q);
    end
  end

  // Accumulator stage: read data arrives, saturating add, write back.
  logic               m_v_r;
  logic [INDEX_W-1:0] m_idx_r;
  logic               m_inr_r;
  logic [DATA_W-1:0]  m_w_r;
  logic [DATA_W-1:0]  m_g_r;
  logic               m_gneg_r;
  logic [ACC_W-1:0]   m_sq_r;
  logic [ACC_W-1:0]   rd_data;
  logic               fwd_v_r;
  logic [INDEX_W-1:0] fwd_idx_r;
  logic [ACC_W-1:0]   fwd_acc_r;
  logic [ACC_W-1:0]   acc_old;
  logic [ACC_W:0]     acc_sum;
  logic               acc_sat;
  logic [ACC_W-1:0]   acc_new;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_idx_r  <= b_idx_r;
      m_inr_r  <= (32'(b_idx_r) < 32'(WEIGHT_COUNT));
      m_w_r    <= b_w_r;
      m_g_r    <= b_g_r;
      m_gneg_r <= b_gneg_r;
      m_sq_r   <= b_sq_r;
    end
  end

  // The entry written by the item just ahead is not yet in the read data.
  always_comb begin
    if (!m_inr_r) begin
      acc_old = '0;
    end else if (fwd_v_r && (fwd_idx_r == m_idx_r)) begin
      acc_old = fwd_acc_r;
    end else begin
      acc_old = rd_data;
    end
    acc_sum = {1'b0, acc_old} + {1'b0, m_sq_r};
    acc_sat = acc_sum[ACC_W];
    acc_new = acc_sat ? '1 : acc_sum[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_idx_r <= m_idx_r;
      fwd_acc_r <= acc_new;
    end
  end

  // RAM port: clearing pass first, then accumulator write-back.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [ACC_W-1:0] ram_wdata;

  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = adv && m_v_r && m_inr_r;
      ram_waddr = AW'(m_idx_r);
      ram_wdata = acc_new;
    end
  end

  awu_ram #(.W(ACC_W), .DEPTH(WEIGHT_COUNT)) u_acc_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (adv),
    .raddr(AW'(b_idx_r)),
    .rdata(rd_data)
  );

  // Updated accumulator registered before epsilon and the root.
  logic              n_v_r;
  logic [ACC_W-1:0]  n_acc_r;
  logic [DATA_W-1:0] n_w_r;
  logic [DATA_W-1:0] n_g_r;
  logic              n_gneg_r;
  logic              n_sat_r;
  logic [ACC_W:0]    tot_sum;
  logic [ACC_W-1:0]  tot;

  always_ff @(posedge clk) begin
    if (adv) begin
      n_acc_r  <= acc_new;
      n_w_r    <= m_w_r;
      n_g_r    <= m_g_r;
      n_gneg_r <= m_gneg_r;
      n_sat_r  <= acc_sat;
    end
  end

  // Epsilon add saturates without raising the flag.
  assign tot_sum = {1'b0, n_acc_r} + {1'b0, EPS_Q32};
  assign tot     = tot_sum[ACC_W] ? '1 : tot_sum[ACC_W-1:0];

  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  logic [S2_W-1:0]   sq_side;

  awu_sqrt_pipe #(.SW(S2_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (n_v_r),
    .rad      (tot),
    .side_in  ({n_w_r, n_g_r, n_gneg_r, n_sat_r}),
    .out_valid(sq_v),
    .root     (sq_root),
    .side_out (sq_side)
  );

  // Adjusted rate: learning rate in Q16.16 over the Q16.16 root.
  logic               d2_v;
  logic [DIV2_NW-1:0] d2_q;
  logic [S2_W-1:0]    d2_side;

  awu_div_pipe #(.NW(DIV2_NW), .DW(ROOT_W), .SW(S2_W)) u_div_rate (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (sq_v),
    .num      ({lr_r, 16'd0}),
    .den      (sq_root),
    .side_in  (sq_side),
    .out_valid(d2_v),
    .quo      (d2_q),
    .side_out (d2_side)
  );

  // Step = adjusted rate times |g|, Q16.16, built from two partial products.
  logic              p1_v_r;
  logic [63:0]       p1_lo_r;
  logic [15:0]       p1_ahi_r;
  logic [DATA_W-1:0] p1_w_r;
  logic [DATA_W-1:0] p1_g_r;
  logic              p1_gneg_r;
  logic              p1_sat_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      {p1_w_r, p1_g_r, p1_gneg_r, p1_sat_r} <= d2_side;
      p1_lo_r  <= 64'(d2_q[31:0]) * 64'(d2_side[S2_W-DATA_W-1:2]);
      p1_ahi_r <= d2_q[DIV2_NW-1:32];
    end
  end

  logic              p2_v_r;
  logic [47:0]       p2_hi_r;
  logic [47:0]       p2_losh_r;
  logic [DATA_W-1:0] p2_w_r;
  logic              p2_gneg_r;
  logic              p2_sat_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_hi_r   <= 48'(p1_ahi_r) * 48'(p1_g_r);
      p2_losh_r <= p1_lo_r[63:16];
      p2_w_r    <= p1_w_r;
      p2_gneg_r <= p1_gneg_r;
      p2_sat_r  <= p1_sat_r;
    end
  end

  logic              p3_v_r;
  logic [63:0]       p3_step_r;
  logic [DATA_W-1:0] p3_w_r;
  logic              p3_gneg_r;
  logic              p3_sat_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_step_r <= {p2_hi_r[47:0], 16'd0} + {16'd0, p2_losh_r};
      p3_w_r    <= p2_w_r;
      p3_gneg_r <= p2_gneg_r;
      p3_sat_r  <= p2_sat_r;
    end
  end

  // New weight with clamping to the signed Q16.16 range.
  logic signed [65:0] nw_wide;
  logic               nw_hi;
  logic               nw_lo;
  logic [DATA_W-1:0]  nw;

  always_comb begin
    if (p3_gneg_r) begin
      nw_wide = $signed({{34{p3_w_r[DATA_W-1]}}, p3_w_r}) + $signed({2'b00, p3_step_r});
    end else begin
      nw_wide = $signed({{34{p3_w_r[DATA_W-1]}}, p3_w_r}) - $signed({2'b00, p3_step_r});
    end
    nw_hi = (nw_wide > 66'sd2147483647);
    nw_lo = (nw_wide < -66'sd2147483648);
    if (nw_hi) begin
      nw = 32'h7FFF_FFFF;
    end else if (nw_lo) begin
      nw = 32'h8000_0000;
    end else begin
      nw = nw_wide[DATA_W-1:0];
    end
  end

  logic              z_v_r;
  logic [DATA_W-1:0] z_w_r;
  logic              z_sat_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      z_w_r   <= nw;
      z_sat_r <= p3_sat_r || nw_hi || nw_lo;
    end
  end

  // Valid bits of the stages outside the divider and root units.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      m_v_r   <= 1'b0;
      fwd_v_r <= 1'b0;
      n_v_r   <= 1'b0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      p3_v_r  <= 1'b0;
      z_v_r   <= 1'b0;
    end else if (adv) begin
      a_v_r   <= in_xfer;
      b_v_r   <= d1_v;
      m_v_r   <= b_v_r;
      fwd_v_r <= m_v_r && m_inr_r;
      n_v_r   <= m_v_r;
      p1_v_r  <= d2_v;
      p2_v_r  <= p1_v_r;
      p3_v_r  <= p2_v_r;
      z_v_r   <= p3_v_r;
    end
  end

  // Output register with a skid register behind it.
  logic              out_v_r;
  logic [DATA_W-1:0] out_w_r;
  logic              out_sat_r;
  logic [DATA_W-1:0] skid_w_r;
  logic              skid_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ch.ready) begin
        out_w_r   <= skid_w_r;
        out_sat_r <= skid_sat_r;
        skid_v_r  <= 1'b0;
      end
    end else if (z_v_r) begin
      if (!out_v_r || out_ch.ready) begin
        out_w_r   <= z_w_r;
        out_sat_r <= z_sat_r;
        out_v_r   <= 1'b1;
      end else begin
        skid_w_r   <= z_w_r;
        skid_sat_r <= z_sat_r;
        skid_v_r   <= 1'b1;
      end
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.weight_out = out_w_r;
  assign out_ch.saturated  = out_sat_r;

endmodule
`default_nettype wire

/* rtl/awu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module awu_ram import awu_pkg::*; #(
  parameter int W     = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/awu_div_pipe.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module awu_div_pipe import awu_pkg::*; #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic      [NW-1:0] quo,
  output logic      [SW-1:0] side_out
);

  logic          v_r      [NW];
  logic [DW-1:0] rem_r    [NW];
  logic [DW-1:0] den_r    [NW];
  logic [NW-1:0] wd_r     [NW];
  logic [SW-1:0] side_r   [NW];
  logic [DW-1:0] rem_nxt  [NW];
  logic [NW-1:0] wd_nxt   [NW];

  // One restoring step per stage; the word shifts numerator bits out and
  // quotient bits in, so it holds the quotient after the last stage.
  always_comb begin
    logic [DW-1:0] rem_src;
    logic [DW-1:0] den_src;
    logic [NW-1:0] wd_src;
    logic [DW:0]   trial;
    logic          ge;
    for (int s = 0; s < NW; s++) begin
      if (s == 0) begin
        rem_src = '0;
        den_src = den;
        wd_src  = num;
      end else begin
        rem_src = rem_r[s-1];
        den_src = den_r[s-1];
        wd_src  = wd_r[s-1];
      end
      trial      = {rem_src, wd_src[NW-1]};
      ge         = (trial >= {1'b0, den_src});
      rem_nxt[s] = ge ? DW'(trial - {1'b0, den_src}) : trial[DW-1:0];
      wd_nxt[s]  = {wd_src[NW-2:0], ge};
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NW; s++) begin
        rem_r[s] <= rem_nxt[s];
        wd_r[s]  <= wd_nxt[s];
        if (s == 0) begin
          den_r[s]  <= den;
          side_r[s] <= side_in;
        end else begin
          den_r[s]  <= den_r[s-1];
          side_r[s] <= side_r[s-1];
        end
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NW; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (en) begin
      for (int s = 0; s < NW; s++) begin
        if (s == 0) begin
          v_r[s] <= in_valid;
        end else begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  assign out_valid = v_r[NW-1];
  assign quo       = wd_r[NW-1];
  assign side_out  = side_r[NW-1];

endmodule
`default_nettype wire

/* rtl/awu_sqrt_pipe.sv */
// Pipelined 64-bit integer square root, one root bit per stage, with sideband.
`default_nettype none
module awu_sqrt_pipe import awu_pkg::*; #(
  parameter int SW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [ACC_W-1:0]  rad,
  input  wire logic [SW-1:0]     side_in,
  output logic                   out_valid,
  output logic      [ROOT_W-1:0] root,
  output logic      [SW-1:0]     side_out
);

  localparam int RW = ROOT_W + 2;

  logic              v_r      [ROOT_W];
  logic [RW-1:0]     rem_r    [ROOT_W];
  logic [ROOT_W-1:0] root_r   [ROOT_W];
  logic [ACC_W-1:0]  rad_r    [ROOT_W];
  logic [SW-1:0]     side_r   [ROOT_W];
  logic [RW-1:0]     rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];

  // Digit-by-digit root: bring down two radicand bits, try root*4+1.
  always_comb begin
    logic [RW-1:0]     rem_src;
    logic [ROOT_W-1:0] root_src;
    logic [ACC_W-1:0]  rad_src;
    logic [RW+1:0]     remsh;
    logic [RW+1:0]     trial;
    logic              ge;
    for (int s = 0; s < ROOT_W; s++) begin
      if (s == 0) begin
        rem_src  = '0;
        root_src = '0;
        rad_src  = rad;
      end else begin
        rem_src  = rem_r[s-1];
        root_src = root_r[s-1];
        rad_src  = rad_r[s-1];
      end
      remsh       = {rem_src, rad_src[ACC_W-1:ACC_W-2]};
      trial       = {2'b00, root_src, 2'b01};
      ge          = (remsh >= trial);
      rem_nxt[s]  = ge ? RW'(remsh - trial) : remsh[RW-1:0];
      root_nxt[s] = {root_src[ROOT_W-2:0], ge};
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < ROOT_W; s++) begin
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        if (s == 0) begin
          rad_r[s]  <= {rad[ACC_W-3:0], 2'b00};
          side_r[s] <= side_in;
        end else begin
          rad_r[s]  <= {rad_r[s-1][ACC_W-3:0], 2'b00};
          side_r[s] <= side_r[s-1];
        end
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ROOT_W; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (en) begin
      for (int s = 0; s < ROOT_W; s++) begin
        if (s == 0) begin
          v_r[s] <= in_valid;
        end else begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign root      = root_r[ROOT_W-1];
  assign side_out  = side_r[ROOT_W-1];

endmodule
`default_nettype wire

/* rtl/awu_chk.sv */
// Port-level checker for the Adagrad weight update block, with its bind.
`default_nettype none
module awu_chk import awu_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] weight_out,
  input wire logic              saturated
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(weight_out) && $stable(saturated))
    else $error("result payload changed while stalled");

  // Reset empties the result side.
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // The clearing pass keeps the input closed after reset.
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input open during accumulator clearing");

endmodule

bind adagrad_weight_update awu_chk u_awu_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .weight_out(out_ch.weight_out),
  .saturated (out_ch.saturated)
);
`default_nettype wire

/* sim/adagrad_weight_update_test.sv */
// Self-checking testbench for the Adagrad weight update pipeline.
`default_nettype none
module adagrad_weight_update_test;
  import awu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WCOUNT = 131072;
  localparam int LATENCY = 121;
  localparam longint CYCLE_LIMIT = 64'd900000;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [DATA_W-1:0]  w;
    logic [DATA_W-1:0]  g;
  } update_t;

  typedef struct packed {
    logic [DATA_W-1:0] w;
    logic              sat;
  } weight_result_t;

  logic clk;
  logic rst_n;
  awu_in_if  in_ch();
  awu_out_if out_ch();
  awu_cfg_if cfg_ch();

  adagrad_weight_update #(.WEIGHT_COUNT(WCOUNT)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Predictor state: accumulators and register copies.
  logic [ACC_W-1:0]   sq_grad_acc [logic [INDEX_W-1:0]];
  logic [DATA_W-1:0]  model_lr;
  logic [BATCH_W-1:0] model_bs;

  update_t        pending_updates[$];
  weight_result_t expected_weights[$];
  int  mismatches;
  bit  no_idle;
  bit  sender_hold;
  int  out_hold_cycles;
  int  sender_gap;
  int  recv_gap;
  longint cycle_count;

  // Clock.
  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  function automatic logic [ACC_W-1:0] int_sqrt(input logic [ACC_W-1:0] v);
    logic [ACC_W-1:0] rem, res, bitv;
    rem = v; res = 0; bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Compute the updated weight and advance the accumulator of its index.
  function automatic weight_result_t adagrad_step(input update_t u);
    logic              neg, sat, in_range;
    logic [ACC_W-1:0]  mag, bs, acc, sq, tot, r, adj, step;
    logic signed [ACC_W:0] nw;
    weight_result_t res;
    neg = u.g[DATA_W-1];
    mag = neg ? {32'd0, (~u.g) + 32'd1} : {32'd0, u.g};
    if (u.g == 32'h8000_0000) mag = 64'h8000_0000;
    bs = (model_bs == 0) ? 64'd1 : {48'd0, model_bs};
    mag = mag / bs;
    if (mag == 0) neg = 1'b0;
    in_range = u.idx < WCOUNT;
    acc = (in_range && sq_grad_acc.exists(u.idx)) ? sq_grad_acc[u.idx] : 64'd0;
    sq = mag * mag;
    sat = 1'b0;
    if (acc > ~sq) begin
      acc = '1;
      sat = 1'b1;
    end else begin
      acc = acc + sq;
    end
    if (in_range) sq_grad_acc[u.idx] = acc;
    tot = (acc > ~EPS_Q32) ? '1 : acc + EPS_Q32;
    r = int_sqrt(tot);
    adj = {model_lr, 16'd0} / r;
    step = (((adj >> 32) * mag) << 16) + (((adj & 64'hFFFF_FFFF) * mag) >> 16);
    nw = {{33{u.w[DATA_W-1]}}, u.w};
    nw = neg ? nw + $signed({1'b0, step}) : nw - $signed({1'b0, step});
    if (nw > 65'sd2147483647) begin
      nw = 65'sd2147483647; sat = 1'b1;
    end else if (nw < -65'sd2147483648) begin
      nw = -65'sd2147483648; sat = 1'b1;
    end
    res.w = nw[DATA_W-1:0];
    res.sat = sat;
    return res;
  endfunction

  // Driver: offer queued updates, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      sender_gap  <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_weights.push_back(adagrad_step(pending_updates.pop_front()));
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Keep offering the same item.
      end else if (sender_gap > 0) begin
        sender_gap  <= sender_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_updates.size() > 0 && !sender_hold) begin
        if (!no_idle && $urandom_range(0, 9) == 0) begin
          sender_gap  <= $urandom_range(1, 6) - 1;
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid        <= 1'b1;
          in_ch.weight_index <= pending_updates[0].idx;
          in_ch.weight_in    <= pending_updates[0].w;
          in_ch.gradient_sum <= pending_updates[0].g;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready with random stalls and a forced long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= 0;
    end else if (out_hold_cycles > 0) begin
      out_hold_cycles <= out_hold_cycles - 1;
      out_ch.ready    <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap     <= recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      recv_gap     <= $urandom_range(1, 6) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    weight_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_weights.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected result transfer: w=%h sat=%b",
                                      out_ch.weight_out, out_ch.saturated);
      end else begin
        exp_r = expected_weights.pop_front();
        if (out_ch.weight_out !== exp_r.w || out_ch.saturated !== exp_r.sat) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Mismatch: expected w=%h sat=%b, got w=%h sat=%b",
                     exp_r.w, exp_r.sat, out_ch.weight_out, out_ch.saturated);
        end
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_update(input int idx, input logic [31:0] w,
                             input logic [31:0] g);
    update_t u;
    u.idx = INDEX_W'(idx); u.w = w; u.g = g;
    pending_updates.push_back(u);
  endtask

  task automatic drain_all();
    while (pending_updates.size() > 0 || in_ch.valid || expected_weights.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // Write a register at an idle point; the predictor follows at the transfer.
  task automatic write_reg(input cfg_index_t idx, input logic [DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_STEP_SIZE) model_lr = val;
    else model_bs = val[BATCH_W-1:0];
  endtask

  // A random gradient, often small so the accumulator grows slowly.
  function automatic logic [31:0] rand_grad();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      2: return $urandom_range(0, 255) - 128;
      default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
  endfunction

  task automatic random_phase(input int n);
    logic [INDEX_W-1:0] base;
    for (int i = 0; i < n; i++) begin
      base = INDEX_W'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 63));
      push_update(int'(base), $urandom(), rand_grad());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    mismatches = 0; cycle_count = 0; no_idle = 1'b0; sender_hold = 1'b0;
    out_hold_cycles = 0;
    in_ch.valid = 1'b0; in_ch.weight_index = '0; in_ch.weight_in = '0;
    in_ch.gradient_sum = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_STEP_SIZE; cfg_ch.data = '0;
    model_lr = LR_RESET; model_bs = BS_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, repeated index, saturation of weight and acc.
    push_update(0, 32'h0001_0000, 32'h0000_8000);
    push_update(0, 32'h0001_0000, 32'h0000_8000);
    push_update(17'h1FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    push_update(17'h1FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_update(5, 32'h0, 32'h0);
    push_update(6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_update(7, 32'h0000_0001, 32'h0000_0001);
    for (int i = 0; i < 6; i++) push_update(9, 32'h7FFF_FFFF, 32'h8000_0000);
    push_update(10, 32'h7FFF_FFF0, 32'hFFFF_0000);
    push_update(11, 32'h8000_0010, 32'h0001_0000);
    drain_all();

    // Extreme register settings, including batch size zero.
    write_reg(CFG_STEP_SIZE, 32'hFFFF_FFFF);
    write_reg(CFG_SAMPLE_COUNT, 32'd0);
    push_update(20, 32'h0, 32'h0000_0001);
    push_update(21, 32'h7FFF_0000, 32'hFFFF_FFFF);
    push_update(22, 32'h8000_0000, 32'h7FFF_FFFF);
    push_update(23, 32'h1234_5678, 32'h8000_0000);
    drain_all();
    write_reg(CFG_SAMPLE_COUNT, 32'hFFFF);
    write_reg(CFG_STEP_SIZE, 32'd0);
    push_update(24, 32'h5555_AAAA, 32'h8000_0000);
    push_update(25, 32'hAAAA_5555, 32'h7FFF_FFFF);
    push_update(26, 32'h0, 32'h0000_FFFE);
    drain_all();

    // Random phases across several settings.
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_STEP_SIZE, p == 0 ? 32'd655 : $urandom());
      write_reg(CFG_SAMPLE_COUNT, $urandom_range(1, p == 3 ? 65535 : 64));
      if (p == 1) begin
        // Long receiver hold-off while the sender keeps offering.
        out_hold_cycles = 400;
      end
      random_phase(400);
      drain_all();
    end

    // Sender pause until all results have come, then a final burst without idling.
    write_reg(CFG_STEP_SIZE, 32'h0001_0000);
    write_reg(CFG_SAMPLE_COUNT, 32'd1);
    random_phase(150);
    sender_hold = 1'b1;
    while (expected_weights.size() > 0 || in_ch.valid) @(posedge clk);
    sender_hold = 1'b0;
    no_idle = 1'b1;
    random_phase(150);
    drain_all();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
